/* design/tsvt_pkg.sv */
// shared constants and helpers for the tsv cell offset tokenizer
// no dependencies
package tsvt_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int ROW_BITS_DEF    = 16;

    // fixed width of the column port
    localparam int COL_BITS = 6;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_CR  = 8'h0d;
    localparam logic [7:0] BYTE_LF  = 8'h0a;

    // width of one packed command word
    function automatic int cmd_width(input int off_bits, input int row_bits,
                                     input int cnt_bits);
        return 3 + row_bits + 3 * cnt_bits + 3 * off_bits;
    endfunction

endpackage

/* design/tsv_cell_offset_tokenizer.sv */
// tsv cell offset tokenizer: one byte in and one record out per cycle, unless stalled
// path: a byte's records pass the front, the queue and the output register in turn
// throughput: 1 byte/cycle until the 4-deep queue fills; a line end or eof byte yields
// up to MAX_COLUMNS records, emitted one per cycle by the back part unless output stalls
// reset: synchronous active-low i_rst_n clears state to start of a new file
// depends on tsvt_pkg, tsvt_front, tsvt_cmd_queue, tsvt_back
module tsv_cell_offset_tokenizer #(
    parameter int MAX_COLUMNS = tsvt_pkg::MAX_COLUMNS_DEF,
    parameter int OFFSET_BITS = tsvt_pkg::OFFSET_BITS_DEF,
    parameter int ROW_BITS    = tsvt_pkg::ROW_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_file,
    output logic                          empty,
    input  logic                          pop,
    output logic [ROW_BITS-1:0]           o_row_index,
    output logic [tsvt_pkg::COL_BITS-1:0] o_column_index,
    output logic [OFFSET_BITS-1:0]        o_cell_offset,
    output logic [OFFSET_BITS-1:0]        o_cell_length,
    output logic                          o_is_padding,
    output logic                          o_last_record
);

    localparam int CNT_BITS = $clog2(MAX_COLUMNS + 1);
    localparam int CMD_W    = tsvt_pkg::cmd_width(OFFSET_BITS, ROW_BITS, CNT_BITS);

    logic             accept;
    logic             cmd_push;
    logic [CMD_W-1:0] cmd_in;
    logic             q_full;
    logic             q_valid;
    logic [CMD_W-1:0] q_head;
    logic             q_pop;
    logic             out_valid;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    tsvt_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .OFFSET_BITS (OFFSET_BITS),
        .ROW_BITS    (ROW_BITS),
        .CNT_BITS    (CNT_BITS),
        .CMD_W       (CMD_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_cmd_valid   (cmd_push),
        .o_cmd         (cmd_in)
    );

    tsvt_cmd_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_head)
    );

    tsvt_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .OFFSET_BITS (OFFSET_BITS),
        .ROW_BITS    (ROW_BITS),
        .CNT_BITS    (CNT_BITS),
        .CMD_W       (CMD_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (q_head),
        .o_cmd_pop      (q_pop),
        .o_out_valid    (out_valid),
        .i_out_pop      (pop),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_cell_offset  (o_cell_offset),
        .o_cell_length  (o_cell_length),
        .o_is_padding   (o_is_padding),
        .o_last_record  (o_last_record)
    );

endmodule

/* design/tsvt_front.sv */
// front part: classifies each byte, tracks row/column/offset state and
// issues one command per byte that yields records; uses tsvt_pkg
module tsvt_front #(
    parameter int MAX_COLUMNS = tsvt_pkg::MAX_COLUMNS_DEF,
    parameter int OFFSET_BITS = tsvt_pkg::OFFSET_BITS_DEF,
    parameter int ROW_BITS    = tsvt_pkg::ROW_BITS_DEF,
    parameter int CNT_BITS    = $clog2(MAX_COLUMNS + 1),
    parameter int CMD_W       = tsvt_pkg::cmd_width(OFFSET_BITS, ROW_BITS, CNT_BITS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_file,
    output logic             o_cmd_valid,
    output logic [CMD_W-1:0] o_cmd
);

    typedef struct packed {
        logic                   has_cell;
        logic                   first_real;
        logic                   eof;
        logic [ROW_BITS-1:0]    row;
        logic [CNT_BITS-1:0]    col;
        logic [OFFSET_BITS-1:0] cell_off;
        logic [OFFSET_BITS-1:0] cell_len;
        logic [CNT_BITS-1:0]    pad_from;
        logic [CNT_BITS-1:0]    pad_to;
        logic [OFFSET_BITS-1:0] pad_off;
    } t_cmd;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX   = {OFFSET_BITS{1'b1}};
    localparam logic [ROW_BITS-1:0]    ROW_MAX   = {ROW_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]    COL_LIMIT = CNT_BITS'(MAX_COLUMNS);

    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [CNT_BITS-1:0]    r_col, n_col;
    logic [CNT_BITS-1:0]    r_width, n_width;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic                   r_first, n_first;
    logic                   r_prev_cr, n_prev_cr;
    logic                   r_skip, n_skip;

    logic [OFFSET_BITS-1:0] next_pos;
    logic [CNT_BITS-1:0]    col_p1;
    logic [CNT_BITS-1:0]    limit;
    t_cmd                   cmd;

    assign next_pos = (r_pos == OFF_MAX) ? r_pos : r_pos + 1'b1;
    assign col_p1   = r_col + 1'b1;
    assign limit    = r_first ? COL_LIMIT : r_width;

    always_comb begin
        n_pos     = r_pos;
        n_start   = r_start;
        n_col     = r_col;
        n_width   = r_width;
        n_row     = r_row;
        n_first   = r_first;
        n_prev_cr = r_prev_cr;
        n_skip    = r_skip;
        cmd       = '0;
        cmd.row   = r_row;
        cmd.eof   = i_end_of_file;
        cmd.col   = r_col;
        cmd.cell_off = r_start;
        if (i_accept) begin
            n_prev_cr = 1'b0;
            n_pos     = next_pos;
            if (r_prev_cr && (i_data_byte == tsvt_pkg::BYTE_LF)) begin
                // lf of a crlf pair is swallowed
                n_start = next_pos;
            end else if (i_data_byte == tsvt_pkg::BYTE_TAB) begin
                if (!r_skip) begin
                    cmd.has_cell = 1'b1;
                    cmd.cell_len = r_pos - r_start;
                    if (col_p1 < limit) begin
                        n_col = col_p1;
                        if (r_first) begin
                            n_width = col_p1 + 1'b1;
                        end
                    end else begin
                        n_skip = 1'b1;
                    end
                end
                n_start = next_pos;
                // trailing tab at eof: real empty cell, then padding
                if (i_end_of_file && !n_skip) begin
                    cmd.first_real = 1'b1;
                    cmd.pad_from   = n_col;
                    cmd.pad_to     = n_width;
                    cmd.pad_off    = next_pos;
                end
            end else if ((i_data_byte == tsvt_pkg::BYTE_CR) ||
                         (i_data_byte == tsvt_pkg::BYTE_LF)) begin
                cmd.has_cell = !r_skip;
                cmd.cell_len = r_pos - r_start;
                if (r_first) begin
                    n_width = col_p1;
                    n_first = 1'b0;
                end
                cmd.pad_from = col_p1;
                cmd.pad_to   = r_first ? col_p1 : r_width;
                cmd.pad_off  = next_pos;
                n_row     = (r_row == ROW_MAX) ? r_row : r_row + 1'b1;
                n_col     = '0;
                n_skip    = 1'b0;
                n_start   = next_pos;
                n_prev_cr = (i_data_byte == tsvt_pkg::BYTE_CR);
            end else if (i_end_of_file && !r_skip) begin
                cmd.has_cell = 1'b1;
                cmd.cell_len = next_pos - r_start;
                cmd.pad_from = col_p1;
                cmd.pad_to   = r_width;
                cmd.pad_off  = next_pos;
            end
            if (i_end_of_file) begin
                n_pos     = '0;
                n_start   = '0;
                n_col     = '0;
                n_width   = CNT_BITS'(1);
                n_row     = '0;
                n_first   = 1'b1;
                n_prev_cr = 1'b0;
                n_skip    = 1'b0;
            end
        end
    end

    assign o_cmd_valid = i_accept && (cmd.has_cell || (cmd.pad_from < cmd.pad_to));
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_start   <= '0;
            r_col     <= '0;
            r_width   <= CNT_BITS'(1);
            r_row     <= '0;
            r_first   <= 1'b1;
            r_prev_cr <= 1'b0;
            r_skip    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_start   <= n_start;
            r_col     <= n_col;
            r_width   <= n_width;
            r_row     <= n_row;
            r_first   <= n_first;
            r_prev_cr <= n_prev_cr;
            r_skip    <= n_skip;
        end
    end

endmodule

/* design/tsvt_cmd_queue.sv */
// small command queue between front and back parts
// uses tsvt_pkg for its depth
module tsvt_cmd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PTR_W = $clog2(tsvt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tsvt_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [tsvt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(tsvt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/tsvt_back.sv */
// back part: expands each command into cell and padding records,
// one per cycle into the output register unless stalled; uses tsvt_pkg
module tsvt_back #(
    parameter int MAX_COLUMNS = tsvt_pkg::MAX_COLUMNS_DEF,
    parameter int OFFSET_BITS = tsvt_pkg::OFFSET_BITS_DEF,
    parameter int ROW_BITS    = tsvt_pkg::ROW_BITS_DEF,
    parameter int CNT_BITS    = $clog2(MAX_COLUMNS + 1),
    parameter int CMD_W       = tsvt_pkg::cmd_width(OFFSET_BITS, ROW_BITS, CNT_BITS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  logic [CMD_W-1:0]             i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_pop,
    output logic [ROW_BITS-1:0]          o_row_index,
    output logic [tsvt_pkg::COL_BITS-1:0] o_column_index,
    output logic [OFFSET_BITS-1:0]       o_cell_offset,
    output logic [OFFSET_BITS-1:0]       o_cell_length,
    output logic                         o_is_padding,
    output logic                         o_last_record
);

    typedef struct packed {
        logic                   has_cell;
        logic                   first_real;
        logic                   eof;
        logic [ROW_BITS-1:0]    row;
        logic [CNT_BITS-1:0]    col;
        logic [OFFSET_BITS-1:0] cell_off;
        logic [OFFSET_BITS-1:0] cell_len;
        logic [CNT_BITS-1:0]    pad_from;
        logic [CNT_BITS-1:0]    pad_to;
        logic [OFFSET_BITS-1:0] pad_off;
    } t_cmd;

    t_cmd                head;
    logic                r_active;
    logic [CNT_BITS-1:0] r_pad_col;
    logic                r_out_valid;

    logic [CNT_BITS-1:0] cur_col;
    logic [CNT_BITS-1:0] cur_col_p1;
    logic                cell_pend;
    logic                more;
    logic                emit;
    logic [CNT_BITS-1:0] rec_col;

    assign head       = i_cmd;
    assign cur_col    = r_active ? r_pad_col : head.pad_from;
    assign cur_col_p1 = cur_col + 1'b1;
    assign cell_pend  = head.has_cell && !r_active;
    // something left of this command after the record going out now
    assign more       = cell_pend ? (cur_col < head.pad_to) : (cur_col_p1 < head.pad_to);
    assign emit       = i_cmd_valid && (!r_out_valid || i_out_pop);
    assign o_cmd_pop  = emit && !more;
    assign rec_col    = cell_pend ? head.col : cur_col;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pad_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                r_active  <= more;
                r_pad_col <= cell_pend ? cur_col : cur_col_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_row_index    <= head.row;
            o_column_index <= tsvt_pkg::COL_BITS'(rec_col);
            o_last_record  <= head.eof && !more;
            if (cell_pend) begin
                o_cell_offset <= head.cell_off;
                o_cell_length <= head.cell_len;
                o_is_padding  <= 1'b0;
            end else begin
                o_cell_offset <= head.pad_off;
                o_cell_length <= '0;
                // empty cell after a trailing tab is a real cell
                o_is_padding  <= !(head.first_real && (cur_col == head.pad_from));
            end
        end
    end

endmodule

/* sim/tsvt_cell_checker.sv */
`timescale 1ns / 100ps
// checker for the tsv cell offset tokenizer: predicts the cell records of every accepted
// byte, queues them and compares them field by field with the records popped from the block
// depends on tsvt_pkg
module tsvt_cell_checker #(
    parameter int MAX_COLUMNS = tsvt_pkg::MAX_COLUMNS_DEF,
    parameter int OFFSET_BITS = tsvt_pkg::OFFSET_BITS_DEF,
    parameter int ROW_BITS    = tsvt_pkg::ROW_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_file,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  logic [ROW_BITS-1:0]           i_row_index,
    input  logic [tsvt_pkg::COL_BITS-1:0] i_column_index,
    input  logic [OFFSET_BITS-1:0]        i_cell_offset,
    input  logic [OFFSET_BITS-1:0]        i_cell_length,
    input  logic                          i_is_padding,
    input  logic                          i_last_record,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_cells_checked
);

    typedef struct packed {
        logic [ROW_BITS-1:0]           row;
        logic [tsvt_pkg::COL_BITS-1:0] col;
        logic [OFFSET_BITS-1:0]        off;
        logic [OFFSET_BITS-1:0]        len;
        logic                          pad;
        logic                          last;
    } t_cell_rec;

    localparam logic [OFFSET_BITS-1:0] OFF_TOP = '1;
    localparam logic [ROW_BITS-1:0]    ROW_TOP = '1;

    t_cell_rec expected_cells[$];

    // scanner state
    logic [OFFSET_BITS-1:0] scan_pos;
    logic [OFFSET_BITS-1:0] cell_begin;
    logic [ROW_BITS-1:0]    cur_row;
    int unsigned            cur_col;
    int unsigned            tbl_width;
    bit                     first_line;
    bit                     after_cr;
    bit                     dropping;
    int unsigned            cells_this_byte;

    int fail_total   = 0;
    int checked      = 0;

    function automatic void restart_file();
        scan_pos   = '0;
        cell_begin = '0;
        cur_row    = '0;
        cur_col    = 0;
        tbl_width  = 1;
        first_line = 1'b1;
        after_cr   = 1'b0;
        dropping   = 1'b0;
    endfunction

    function automatic void add_cell(input int unsigned c, input logic [OFFSET_BITS-1:0] off,
                                     input logic [OFFSET_BITS-1:0] len, input bit pad);
        t_cell_rec r;
        r.row  = cur_row;
        r.col  = c[tsvt_pkg::COL_BITS-1:0];
        r.off  = off;
        r.len  = len;
        r.pad  = pad;
        r.last = 1'b0;
        expected_cells.push_back(r);
        cells_this_byte++;
    endfunction

    // zero-length cells up to the table width
    function automatic void pad_out(input int unsigned from, input logic [OFFSET_BITS-1:0] off);
        for (int unsigned c = from; c < tbl_width; c++)
            add_cell(c, off, '0, 1'b1);
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input bit eof);
        logic [OFFSET_BITS-1:0] at;
        logic [OFFSET_BITS-1:0] nxt;
        int unsigned            limit;
        t_cell_rec              tail;
        at    = scan_pos;
        nxt   = (at != OFF_TOP) ? at + 1'b1 : OFF_TOP;
        limit = first_line ? MAX_COLUMNS : tbl_width;
        cells_this_byte = 0;

        // lf of a crlf pair
        if (after_cr && b == tsvt_pkg::BYTE_LF) begin
            after_cr   = 1'b0;
            cell_begin = nxt;
            scan_pos   = nxt;
            if (eof)
                restart_file();
            return;
        end
        after_cr = 1'b0;

        if (b == tsvt_pkg::BYTE_TAB) begin
            if (!dropping) begin
                add_cell(cur_col, cell_begin, at - cell_begin, 1'b0);
                if (cur_col + 1 < limit) begin
                    cur_col++;
                    if (first_line)
                        tbl_width = cur_col + 1;
                end else begin
                    dropping = 1'b1;
                end
            end
            cell_begin = nxt;
            // the empty cell after a trailing tab is a real one
            if (eof && !dropping) begin
                add_cell(cur_col, nxt, '0, 1'b0);
                pad_out(cur_col + 1, nxt);
            end
        end else if (b == tsvt_pkg::BYTE_CR || b == tsvt_pkg::BYTE_LF) begin
            if (!dropping)
                add_cell(cur_col, cell_begin, at - cell_begin, 1'b0);
            if (first_line) begin
                tbl_width  = cur_col + 1;
                first_line = 1'b0;
            end
            pad_out(cur_col + 1, nxt);
            if (cur_row != ROW_TOP)
                cur_row++;
            cur_col    = 0;
            dropping   = 1'b0;
            cell_begin = nxt;
            after_cr   = (b == tsvt_pkg::BYTE_CR);
        end else if (eof && !dropping) begin
            add_cell(cur_col, cell_begin, nxt - cell_begin, 1'b0);
            pad_out(cur_col + 1, nxt);
        end

        scan_pos = nxt;
        if (eof) begin
            if (cells_this_byte > 0) begin
                tail = expected_cells.pop_back();
                tail.last = 1'b1;
                expected_cells.push_back(tail);
            end
            restart_file();
        end
    endfunction

    function automatic void check_popped_cell();
        t_cell_rec got;
        t_cell_rec want;
        got.row  = i_row_index;
        got.col  = i_column_index;
        got.off  = i_cell_offset;
        got.len  = i_cell_length;
        got.pad  = i_is_padding;
        got.last = i_last_record;
        if (expected_cells.size() == 0) begin
            fail_total++;
            if (fail_total <= 10)
                $display("unexpected record: row %0d col %0d off %0d len %0d pad %0b last %0b",
                         got.row, got.col, got.off, got.len, got.pad, got.last);
            return;
        end
        want = expected_cells.pop_front();
        checked++;
        if (got.row !== want.row || got.col !== want.col || got.off !== want.off ||
            got.len !== want.len || got.pad !== want.pad || got.last !== want.last) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("record %0d mismatch at %0t", checked, $realtime);
                $display("  expected row %0d col %0d off %0d len %0d pad %0b last %0b",
                         want.row, want.col, want.off, want.len, want.pad, want.last);
                $display("  actual   row %0d col %0d off %0d len %0d pad %0b last %0b",
                         got.row, got.col, got.off, got.len, got.pad, got.last);
            end
        end
    endfunction

    initial restart_file();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_file();
        end else begin
            if (i_push && !i_full)
                tokenize_byte(i_data_byte, i_end_of_file);
            if (i_pop && !i_empty)
                check_popped_cell();
        end
        o_fail_count    <= fail_total;
        o_pending       <= expected_cells.size();
        o_cells_checked <= checked;
    end

endmodule

/* sim/tsv_cell_offset_tokenizer_tb.sv */
`timescale 1ns / 100ps
// testbench top for the tsv cell offset tokenizer: feeds directed and random tab-separated
// files byte by byte with random idling on both sides and gives the verdict
// depends on tsvt_pkg, tsv_cell_offset_tokenizer and tsvt_cell_checker
module tsv_cell_offset_tokenizer_tb;

    localparam int COLS          = tsvt_pkg::MAX_COLUMNS_DEF;
    localparam int OFF_BITS      = tsvt_pkg::OFFSET_BITS_DEF;
    localparam int ROW_W         = tsvt_pkg::ROW_BITS_DEF;
    localparam int RANDOM_BYTES  = 30;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    logic [7:0]                    i_data_byte;
    logic                          i_end_of_file;
    logic                          empty;
    logic                          pop;
    logic [ROW_W-1:0]              o_row_index;
    logic [tsvt_pkg::COL_BITS-1:0] o_column_index;
    logic [OFF_BITS-1:0]           o_cell_offset;
    logic [OFF_BITS-1:0]           o_cell_length;
    logic                          o_is_padding;
    logic                          o_last_record;

    int  fail_count;
    int  pending;
    int  cells_checked;
    int  cycle_count  = 0;
    int  bytes_sent   = 0;
    int  files_sent   = 0;
    int  random_bytes = 0;
    bit  calm;

    logic [7:0] file_bytes[$];

    tsv_cell_offset_tokenizer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_file  (i_end_of_file),
        .empty          (empty),
        .pop            (pop),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_cell_offset  (o_cell_offset),
        .o_cell_length  (o_cell_length),
        .o_is_padding   (o_is_padding),
        .o_last_record  (o_last_record)
    );

    tsvt_cell_checker #(
        .MAX_COLUMNS (COLS),
        .OFFSET_BITS (OFF_BITS),
        .ROW_BITS    (ROW_W)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_data_byte     (i_data_byte),
        .i_end_of_file   (i_end_of_file),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_row_index     (o_row_index),
        .i_column_index  (o_column_index),
        .i_cell_offset   (o_cell_offset),
        .i_cell_length   (o_cell_length),
        .i_is_padding    (o_is_padding),
        .i_last_record   (o_last_record),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_cells_checked (cells_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d records still expected", cycle_count, pending);
        $display("TEST FAILED");
        $finish;
    end

    // result side stalls at random unless in a calm stretch
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            pop <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit eof);
        while (!calm && $urandom_range(0, 99) < 8) begin
            push        <= 1'b0;
            i_data_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_data_byte   <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    // sends the file held in file_bytes, eof on its last byte
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
        file_bytes.delete();
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return tsvt_pkg::BYTE_TAB;
            1:       return tsvt_pkg::BYTE_CR;
            2:       return tsvt_pkg::BYTE_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_text(input int unsigned max_len);
        logic [7:0]  t;
        int unsigned n;
        n = $urandom_range(0, max_len);
        repeat (n) begin
            t = 8'($urandom);
            while (t == tsvt_pkg::BYTE_TAB || t == tsvt_pkg::BYTE_CR ||
                   t == tsvt_pkg::BYTE_LF)
                t = 8'($urandom);
            file_bytes.push_back(t);
        end
    endfunction

    function automatic void add_cells(input int unsigned cells);
        for (int unsigned c = 0; c < cells; c++) begin
            if (c != 0)
                file_bytes.push_back(tsvt_pkg::BYTE_TAB);
            add_text(3);
        end
    endfunction

    function automatic void add_line_end();
        case ($urandom_range(0, 2))
            0: file_bytes.push_back(tsvt_pkg::BYTE_LF);
            1: file_bytes.push_back(tsvt_pkg::BYTE_CR);
            default: begin
                file_bytes.push_back(tsvt_pkg::BYTE_CR);
                file_bytes.push_back(tsvt_pkg::BYTE_LF);
            end
        endcase
    endfunction

    // well-formed table with short and overlong lines, sometimes corrupted
    function automatic void build_table_file();
        int unsigned width;
        int unsigned spot;
        width = $urandom_range(1, 6);
        add_cells(width);
        add_line_end();
        repeat ($urandom_range(0, 4)) begin
            add_cells($urandom_range(1, width + 2));
            add_line_end();
        end
        if ($urandom_range(0, 1))
            add_cells($urandom_range(1, width + 2));
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                spot = $urandom_range(0, file_bytes.size() - 1);
                file_bytes[spot] = noise_byte();
            end
        end
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_data_byte   <= 8'h00;
        i_end_of_file <= 1'b0;
        calm          <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extreme bytes, crlf, short second line, eof on text
        file_bytes = '{8'hff, tsvt_pkg::BYTE_TAB, 8'h00, tsvt_pkg::BYTE_CR,
                       tsvt_pkg::BYTE_LF, 8'h41};
        send_file();
        // trailing tab at eof
        file_bytes = '{tsvt_pkg::BYTE_TAB};
        send_file();
        // line end at eof, cr then a fresh lf
        file_bytes = '{tsvt_pkg::BYTE_CR};
        send_file();
        file_bytes = '{tsvt_pkg::BYTE_LF};
        send_file();
        // eof on the lf of a crlf
        file_bytes = '{tsvt_pkg::BYTE_TAB, tsvt_pkg::BYTE_CR, tsvt_pkg::BYTE_LF};
        send_file();
        // surplus cells dropped, empty line padded, cr at eof
        file_bytes = '{8'h41, tsvt_pkg::BYTE_TAB, tsvt_pkg::BYTE_LF, 8'h43,
                       tsvt_pkg::BYTE_TAB, 8'h44, tsvt_pkg::BYTE_TAB, 8'h45,
                       tsvt_pkg::BYTE_LF, tsvt_pkg::BYTE_CR};
        send_file();
        // eof while dropping surplus cells
        file_bytes = '{tsvt_pkg::BYTE_TAB, tsvt_pkg::BYTE_LF, tsvt_pkg::BYTE_TAB,
                       tsvt_pkg::BYTE_TAB, 8'h41};
        send_file();

        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 10)) file_bytes.push_back(noise_byte());
            end else begin
                build_table_file();
            end
            random_bytes += file_bytes.size();
            send_file();
        end

        // calm stretch: first line of empty cells wider than the column limit,
        // then short lines
        calm <= 1'b1;
        repeat (COLS + 1) file_bytes.push_back(tsvt_pkg::BYTE_TAB);
        add_line_end();
        add_cells(1);
        add_line_end();
        add_cells(3);
        file_bytes.push_back(tsvt_pkg::BYTE_TAB);
        send_file();
        calm <= 1'b0;

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d bytes in %0d files, %0d cell records checked", bytes_sent, files_sent,
                 cells_checked);
        $display("covered lf/cr/crlf line ends, padding, surplus cells, 64-column table, "
                 , "trailing tab and line end at eof");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/tsvt_pkg.sv
design/tsvt_front.sv
design/tsvt_cmd_queue.sv
design/tsvt_back.sv
design/tsv_cell_offset_tokenizer.sv
sim/tsvt_cell_checker.sv
sim/tsv_cell_offset_tokenizer_tb.sv
